// File: hw/rtl/ssi_pkg.sv
// Shared types and constants for the substring search with ignore set.
package ssi_pkg;

   localparam int PATTERN_DEPTH_DEF = 64;
   localparam int BYTE_W            = 8;
   localparam int OFFSET_W          = 32;
   localparam int OP_W              = 3;
   localparam int STATUS_W          = 2;
   localparam int IGNORE_ENTRIES    = 1 << BYTE_W;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR   = 3'd0,
      OP_PATTERN = 3'd1,
      OP_IGNORE  = 3'd2,
      OP_TEXT    = 3'd3,
      OP_RESTART = 3'd4
   } ssi_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_MATCH = 2'd1,
      ST_FULL  = 2'd2,
      ST_IDLE  = 2'd3
   } ssi_status_type;

   typedef struct packed {
      logic pat_clear;
      logic pat_push;
      logic txt_restart;
      logic txt_push;
   } ssi_win_ctrl_type;

   typedef struct packed {
      logic                pat_full;
      logic                pat_empty;
      logic                hit;
      logic [OFFSET_W-1:0] first_offset;
   } ssi_win_stat_type;

endpackage

// File: hw/rtl/ssi_window.sv
// Pattern store, kept-byte window and parallel compare.
module ssi_window import ssi_pkg::*; #(
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ssi_win_ctrl_type    ctrl,
   input  logic [BYTE_W-1:0]   data_byte,
   input  logic [OFFSET_W-1:0] raw_offset,
   output ssi_win_stat_type    stat
);

   // lane 0 holds the newest byte in both the pattern and the window
   logic [BYTE_W-1:0]        pat_ff   [PATTERN_DEPTH];
   logic [PATTERN_DEPTH-1:0] lane_en_ff;
   logic [BYTE_W-1:0]        win_ff   [PATTERN_DEPTH];
   logic [OFFSET_W-1:0]      woff_ff  [PATTERN_DEPTH];
   logic [PATTERN_DEPTH-1:0] wfill_ff;

   logic [BYTE_W-1:0]        win_in   [PATTERN_DEPTH];
   logic [OFFSET_W-1:0]      woff_in  [PATTERN_DEPTH];
   logic [PATTERN_DEPTH-1:0] wfill_in;
   logic [PATTERN_DEPTH-1:0] oldest;
   logic [PATTERN_DEPTH-1:0] lane_eq;
   logic [OFFSET_W-1:0]      first_sel;

   always_comb begin
      win_in[0]  = data_byte;
      woff_in[0] = raw_offset;
      for (int k = 1; k < PATTERN_DEPTH; k++) begin
         win_in[k]  = win_ff[k-1];
         woff_in[k] = woff_ff[k-1];
      end
      wfill_in = {wfill_ff[PATTERN_DEPTH-2:0], 1'b1};
      // lane holding the first pattern byte
      oldest   = lane_en_ff & ~{1'b0, lane_en_ff[PATTERN_DEPTH-1:1]};
      first_sel = '0;
      for (int k = 0; k < PATTERN_DEPTH; k++) begin
         lane_eq[k] = (win_in[k] == pat_ff[k]) | ~lane_en_ff[k];
         first_sel  = first_sel | (woff_in[k] & {OFFSET_W{oldest[k]}});
      end
   end

   // compare as if the current byte were shifted in; the caller qualifies it
   assign stat.pat_full     = lane_en_ff[PATTERN_DEPTH-1];
   assign stat.pat_empty    = ~lane_en_ff[0];
   assign stat.hit          = lane_en_ff[0] & (|(wfill_in & oldest)) & (&lane_eq);
   assign stat.first_offset = first_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_en_ff <= '0;
         wfill_ff   <= '0;
      end else begin
         if (ctrl.pat_clear) begin
            lane_en_ff <= '0;
         end else if (ctrl.pat_push) begin
            lane_en_ff <= {lane_en_ff[PATTERN_DEPTH-2:0], 1'b1};
         end
         if (ctrl.txt_restart) begin
            wfill_ff <= '0;
         end else if (ctrl.txt_push) begin
            wfill_ff <= wfill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.pat_push) begin
         pat_ff[0] <= data_byte;
         for (int k = 1; k < PATTERN_DEPTH; k++) begin
            pat_ff[k] <= pat_ff[k-1];
         end
      end
      if (ctrl.txt_push) begin
         for (int k = 0; k < PATTERN_DEPTH; k++) begin
            win_ff[k]  <= win_in[k];
            woff_ff[k] <= woff_in[k];
         end
      end
   end

endmodule

// File: hw/rtl/substring_search_with_ignore_set.sv
// Top level: input register, search control, ignore set and result register.
//
//   channel | ports                                   | direction
//   req     | req_valid req_stall req_operation/data   | in
//   rsp     | rsp_valid rsp_stall rsp_status/found/... | out
//
// One item a cycle unless rsp_stall holds a full result register: an item
// waits in the input register and its result is then registered.
// The window shift, its parallel compare and the oldest-offset select set
// the cycle time. Synchronous reset clears pattern, ignore set and search.
// req_stall rises only while the input register holds an item that cannot
// move because the result register is full and rsp_stall is high.
module substring_search_with_ignore_set import ssi_pkg::*; #(
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [BYTE_W-1:0]   req_data_byte,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_found,
   output logic [OFFSET_W-1:0] rsp_match_start,
   output logic [OFFSET_W-1:0] rsp_match_end
);

   logic                      s1_valid_ff;
   logic [OP_W-1:0]           s1_op_ff;
   logic [BYTE_W-1:0]         s1_byte_ff;

   logic [IGNORE_ENTRIES-1:0] ignore_ff, ignore_in;
   logic [OFFSET_W-1:0]       raw_off_ff, raw_off_in;
   logic                      found_ff, found_in;
   logic [OFFSET_W-1:0]       start_ff, start_in;
   logic [OFFSET_W-1:0]       end_ff, end_in;
   ssi_status_type            status_in;

   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic                      rsp_found_ff;
   logic [OFFSET_W-1:0]       rsp_start_ff;
   logic [OFFSET_W-1:0]       rsp_end_ff;

   logic                      advance;
   logic                      fire;
   logic                      byte_ignored;
   ssi_win_ctrl_type          win_ctrl;
   ssi_win_stat_type          win_stat;

   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign fire      = s1_valid_ff & advance;
   assign req_stall = s1_valid_ff & ~advance;

   assign byte_ignored = ignore_ff[s1_byte_ff];

   ssi_window #(
      .PATTERN_DEPTH(PATTERN_DEPTH)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (win_ctrl),
      .data_byte  (s1_byte_ff),
      .raw_offset (raw_off_ff),
      .stat       (win_stat)
   );

   always_comb begin
      win_ctrl   = '0;
      ignore_in  = ignore_ff;
      raw_off_in = raw_off_ff;
      found_in   = found_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      status_in  = ST_OK;
      case (ssi_op_type'(s1_op_ff))
         OP_CLEAR: begin
            ignore_in            = '0;
            win_ctrl.pat_clear   = fire;
            win_ctrl.txt_restart = fire;
         end
         OP_PATTERN: begin
            win_ctrl.txt_restart = fire;
            if (!byte_ignored) begin
               if (win_stat.pat_full) begin
                  status_in = ST_FULL;
               end else begin
                  win_ctrl.pat_push = fire;
               end
            end
         end
         OP_IGNORE: begin
            win_ctrl.txt_restart  = fire;
            ignore_in[s1_byte_ff] = 1'b1;
         end
         OP_TEXT: begin
            if (win_stat.pat_empty || found_ff) begin
               status_in = ST_IDLE;
            end else begin
               raw_off_in = raw_off_ff + OFFSET_W'(1);
               // ignored text bytes only advance the raw offset
               win_ctrl.txt_push = fire & ~byte_ignored;
               if (!byte_ignored && win_stat.hit) begin
                  found_in  = 1'b1;
                  start_in  = win_stat.first_offset;
                  end_in    = raw_off_ff;
                  status_in = ST_MATCH;
               end
            end
         end
         OP_RESTART: begin
            win_ctrl.txt_restart = fire;
         end
         default: begin
            status_in = ST_IDLE;
         end
      endcase
      if (win_ctrl.txt_restart) begin
         raw_off_in = '0;
         found_in   = 1'b0;
         start_in   = '0;
         end_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ignore_ff    <= '0;
         raw_off_ff   <= '0;
         found_ff     <= 1'b0;
         start_ff     <= '0;
         end_ff       <= '0;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (fire) begin
            ignore_ff  <= ignore_in;
            raw_off_ff <= raw_off_in;
            found_ff   <= found_in;
            start_ff   <= start_in;
            end_ff     <= end_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_op_ff   <= req_operation;
         s1_byte_ff <= req_data_byte;
      end
      if (fire) begin
         rsp_status_ff <= status_in;
         rsp_found_ff  <= found_in;
         rsp_start_ff  <= start_in;
         rsp_end_ff    <= end_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_start = rsp_start_ff;
   assign rsp_match_end   = rsp_end_ff;

   a_match_sets_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_MATCH |-> rsp_found)
      else $error("match reported without found flag");

   a_offsets_zero_when_idle: assert property (@(posedge clock) disable iff (reset)
      !found_ff |-> start_ff == '0 && end_ff == '0)
      else $error("match offsets set while no match found");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked item");

   a_held_after_match: assert property (@(posedge clock) disable iff (reset)
      fire && found_ff && ssi_op_type'(s1_op_ff) == OP_TEXT |=> $stable(start_ff))
      else $error("match offsets moved after a match");

endmodule
